// ----- sv/contrast_pixel_count_top_defines.svh -----
// Assertion macros used by the checker file.
`ifndef CONTRAST_PIXEL_COUNT_TOP_DEFINES_SVH
`define CONTRAST_PIXEL_COUNT_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define CPC_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define CPC_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/cpc_pkg.sv -----
`default_nettype none

package cpc_pkg;

    localparam int MAX_WIDTH_DEF  = 512;
    localparam int MAX_HEIGHT_DEF = 512;

    localparam int FRAME_W = 10;
    localparam int THR_W   = 8;
    localparam int PIX_W   = 8;
    localparam int COUNT_W = 19;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [ADDR_W-3:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [ADDR_W-3:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [ADDR_W-3:0] REG_THRESHOLD    = 2'd2;

    localparam logic [FRAME_W-1:0] FRAME_WIDTH_RST  = 10'd320;
    localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RST = 10'd200;
    localparam logic [THR_W-1:0]   THRESHOLD_RST    = 8'd128;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic [FRAME_W-1:0] frame_width;
        logic [FRAME_W-1:0] frame_height;
        logic [THR_W-1:0]   contrast_threshold;
    } cpc_cfg_t;

endpackage

`default_nettype wire

// ----- sv/cpc_apb_regs.sv -----
`default_nettype none

module cpc_apb_regs
    import cpc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cpc_cfg_t               cfg
);

    logic [FRAME_W-1:0] frame_width_reg;
    logic [FRAME_W-1:0] frame_height_reg;
    logic [THR_W-1:0]   threshold_reg;
    logic               wr_en;
    logic [ADDR_W-3:0]  reg_index;

    assign pready    = 1'b1;
    assign reg_index = paddr[ADDR_W-1:2];
    assign wr_en     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            threshold_reg    <= THRESHOLD_RST;
        end
        else if (wr_en)
        begin
            case (reg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[FRAME_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[FRAME_W-1:0];
                REG_THRESHOLD:    threshold_reg    <= pwdata[THR_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_FRAME_WIDTH:  prdata = {{(DATA_W-FRAME_W){1'b0}}, frame_width_reg};
            REG_FRAME_HEIGHT: prdata = {{(DATA_W-FRAME_W){1'b0}}, frame_height_reg};
            REG_THRESHOLD:    prdata = {{(DATA_W-THR_W){1'b0}}, threshold_reg};
            default:          prdata = '0;
        endcase
    end

    assign cfg.frame_width        = frame_width_reg;
    assign cfg.frame_height       = frame_height_reg;
    assign cfg.contrast_threshold = threshold_reg;

endmodule

`default_nettype wire

// ----- sv/contrast_pixel_count_top.sv -----
// Channel   Direction  Handshake            Payload
// config    in/out     psel/penable/pready  paddr, pwdata, pwrite, prdata
// pixel     in         in_valid/in_stall    pixel (8 bits)
// count     out        out_valid/out_stall  contrast_count (19 bits)
//
// One pixel is accepted every cycle while in_stall is low. The line stores are
// read when a pixel is accepted and compared and written back as it leaves s1,
// so the count of a frame is registered as its last pixel leaves s1. The line
// stores need no clearing after reset. in_stall is raised only while a finished
// count waits in the output register and the next frame's last pixel is in s1.
`default_nettype none

module contrast_pixel_count_top
    import cpc_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [ADDR_W-1:0]  paddr,
    input  wire logic [DATA_W-1:0]  pwdata,
    output logic      [DATA_W-1:0]  prdata,
    output logic                    pready,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [PIX_W-1:0]   pixel,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic      [COUNT_W-1:0] contrast_count
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WEW = ($clog2(MAX_WIDTH + 1) > FRAME_W) ? $clog2(MAX_WIDTH + 1) : FRAME_W;
    localparam int HEW = ($clog2(MAX_HEIGHT + 1) > FRAME_W) ? $clog2(MAX_HEIGHT + 1) : FRAME_W;

    function automatic logic contrasts(input logic [PIX_W-1:0] a,
                                       input logic [PIX_W-1:0] b,
                                       input logic [THR_W-1:0] thr);
        logic [PIX_W-1:0] diff;
        diff = (a > b) ? (a - b) : (b - a);
        return diff > thr;
    endfunction

    cpc_cfg_t cfg;

    logic [CW-1:0]    col_reg;
    logic [RW-1:0]    row_reg;
    logic [WEW-1:0]   fw_ext;
    logic [WEW-1:0]   w_eff;
    logic [HEW-1:0]   fh_ext;
    logic [HEW-1:0]   h_eff;
    logic             last_col;
    logic             last_row;
    logic             accept;

    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_pixel_reg;
    logic [CW-1:0]    s1_col_reg;
    logic             s1_has_up_reg;
    logic             s1_has_left_reg;
    logic             s1_last_col_reg;
    logic             s1_last_row_reg;

    logic [PIX_W-1:0] pix_mem [MAX_WIDTH];
    logic             mark_mem [MAX_WIDTH];
    logic [PIX_W-1:0] pix_rd_reg;
    logic             mark_rd_reg;
    logic             pix_fwd_reg;
    logic [PIX_W-1:0] pix_fwd_data_reg;
    logic             mark_fwd_reg;
    logic             mark_fwd_data_reg;
    logic             pix_fwd_next;
    logic             mark_fwd_next;

    logic             pend_valid_reg;
    logic [CW-1:0]    pend_addr_reg;
    logic             pend_mark_reg;
    logic             pend_valid_next;

    logic [PIX_W-1:0]   left_pixel_reg;
    logic               left_mark_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               out_valid_reg;
    logic [COUNT_W-1:0] out_count_reg;

    logic               emit;
    logic               fire;
    logic [PIX_W-1:0]   up_pixel;
    logic               up_mark;
    logic               up_c;
    logic               left_c;
    logic               cur_mark;
    logic               left_mark_fin;
    logic [1:0]         inc;
    logic [COUNT_W:0]   sum;
    logic [COUNT_W-1:0] count_sat;
    logic               write_left;
    logic               mark_we;
    logic [CW-1:0]      mark_waddr;
    logic               mark_wdata;
    logic               set_pend;

    cpc_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Position of the next pixel against the clamped frame size.
    assign fw_ext = WEW'(cfg.frame_width);
    assign fh_ext = HEW'(cfg.frame_height);
    assign w_eff  = (fw_ext == '0) ? WEW'(1) :
                    (fw_ext > WEW'(MAX_WIDTH)) ? WEW'(MAX_WIDTH) : fw_ext;
    assign h_eff  = (fh_ext == '0) ? HEW'(1) :
                    (fh_ext > HEW'(MAX_HEIGHT)) ? HEW'(MAX_HEIGHT) : fh_ext;
    assign last_col = (WEW'(col_reg) + WEW'(1)) >= w_eff;
    assign last_row = (HEW'(row_reg) + HEW'(1)) >= h_eff;

    assign emit     = s1_last_col_reg && s1_last_row_reg;
    assign fire     = s1_valid_reg && !(emit && out_valid_reg && out_stall);
    assign in_stall = s1_valid_reg && !fire;
    assign accept   = in_valid && !in_stall;

    // Newest copy of the entry above: a pending mark, then a same-edge write, then memory.
    assign up_pixel = pix_fwd_reg ? pix_fwd_data_reg : pix_rd_reg;
    assign up_mark  = (pend_valid_reg && (pend_addr_reg == s1_col_reg)) ? pend_mark_reg :
                      mark_fwd_reg ? mark_fwd_data_reg : mark_rd_reg;

    assign up_c   = s1_has_up_reg &&
                    contrasts(up_pixel, s1_pixel_reg, cfg.contrast_threshold);
    assign left_c = s1_has_left_reg &&
                    contrasts(left_pixel_reg, s1_pixel_reg, cfg.contrast_threshold);
    assign cur_mark      = up_c || left_c;
    assign left_mark_fin = left_mark_reg || left_c;

    assign inc = 2'({1'b0, s1_has_up_reg && (up_mark || up_c)})
               + 2'({1'b0, s1_has_left_reg && s1_last_row_reg && left_mark_fin})
               + 2'({1'b0, emit && cur_mark});
    assign sum       = {1'b0, count_reg} + (COUNT_W+1)'(inc);
    assign count_sat = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];

    // The left neighbor's mark is final now; the last column's mark waits one pixel.
    assign write_left = s1_has_left_reg && !s1_last_row_reg;
    assign mark_we    = fire && (write_left || pend_valid_reg);
    assign mark_waddr = write_left ? (s1_col_reg - CW'(1)) : pend_addr_reg;
    assign mark_wdata = write_left ? left_mark_fin : pend_mark_reg;
    assign set_pend   = s1_last_col_reg && !s1_last_row_reg;

    assign pix_fwd_next  = fire && (s1_col_reg == col_reg);
    assign mark_fwd_next = mark_we && (mark_waddr == col_reg);

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (fire)
        begin
            if (!write_left || (pend_addr_reg == mark_waddr))
            begin
                pend_valid_next = 1'b0;
            end
            if (set_pend)
            begin
                pend_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            pix_mem[s1_col_reg] <= s1_pixel_reg;
        end
        if (accept)
        begin
            pix_rd_reg <= pix_mem[col_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mark_we)
        begin
            mark_mem[mark_waddr] <= mark_wdata;
        end
        if (accept)
        begin
            mark_rd_reg <= mark_mem[col_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg      <= pixel;
            s1_col_reg        <= col_reg;
            s1_has_up_reg     <= (row_reg != '0);
            s1_has_left_reg   <= (col_reg != '0);
            s1_last_col_reg   <= last_col;
            s1_last_row_reg   <= last_row;
            pix_fwd_data_reg  <= s1_pixel_reg;
            mark_fwd_data_reg <= mark_wdata;
        end
        if (fire && set_pend)
        begin
            pend_addr_reg <= s1_col_reg;
            pend_mark_reg <= cur_mark;
        end
        if (fire && emit)
        begin
            out_count_reg <= count_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            s1_valid_reg   <= 1'b0;
            pix_fwd_reg    <= 1'b0;
            mark_fwd_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            left_pixel_reg <= '0;
            left_mark_reg  <= 1'b0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            if (accept)
            begin
                pix_fwd_reg  <= pix_fwd_next;
                mark_fwd_reg <= mark_fwd_next;
                if (!last_col)
                begin
                    col_reg <= col_reg + CW'(1);
                end
                else
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : (row_reg + RW'(1));
                end
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                if (emit)
                begin
                    count_reg      <= '0;
                    left_pixel_reg <= '0;
                    left_mark_reg  <= 1'b0;
                end
                else
                begin
                    count_reg      <= count_sat;
                    left_pixel_reg <= s1_pixel_reg;
                    left_mark_reg  <= cur_mark;
                end
            end
            if (fire && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign contrast_count = out_count_reg;

endmodule

`default_nettype wire

// ----- sv/cpc_checker.sv -----
`default_nettype none
`include "contrast_pixel_count_top_defines.svh"

module cpc_checker
    import cpc_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               psel,
    input wire logic               penable,
    input wire logic               pwrite,
    input wire logic [ADDR_W-1:0]  paddr,
    input wire logic [DATA_W-1:0]  pwdata,
    input wire logic [DATA_W-1:0]  prdata,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire logic [COUNT_W-1:0] contrast_count
);

    // The pixel side is held back only by a count that cannot leave.
    `CPC_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "in_stall without a blocked count")

    `CPC_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(contrast_count), "stalled count changed")

    `CPC_ASSERT_NXT(a_thr_readback, psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_THRESHOLD), (paddr[ADDR_W-1:2] != REG_THRESHOLD) || (prdata[THR_W-1:0] == $past(pwdata[THR_W-1:0])), "threshold readback mismatch")

    `CPC_ASSERT_NOW(a_no_input_stall_idle, !out_valid, !in_stall || !in_valid, "pixel stalled with empty output")

endmodule

bind contrast_pixel_count_top cpc_checker u_cpc_checker (.*);

`default_nettype wire
